@@ src/gfa_pkg.sv @@
// Package: shared types, constants and field helper functions for the Goldilocks field ALU.
package gfa_pkg;

    localparam logic [63:0] FIELD_P   = 64'hFFFF_FFFF_0000_0001;
    localparam logic [63:0] FIELD_EPS = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] INV_EXP   = 64'hFFFF_FFFE_FFFF_FFFF;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0,
        CMD_SUB = 4'd1,
        CMD_MUL = 4'd2,
        CMD_DIV = 4'd3,
        CMD_INV = 4'd4,
        CMD_EXP = 4'd5,
        CMD_NEG = 4'd6,
        CMD_INC = 4'd7,
        CMD_DEC = 4'd8
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PP0,
        ST_PP1,
        ST_PP2,
        ST_PP3,
        ST_FOLD,
        ST_FIN,
        ST_EXP_STEP,
        ST_DONE
    } t_state;

    // Which operation the shared multiplier is serving.
    typedef enum logic [1:0] {
        MOP_PLAIN,
        MOP_ACC,
        MOP_SQR,
        MOP_DIVFIN
    } t_mop;

    // Reduce a value below 2p into [0, p-1].
    function automatic logic [63:0] fred(input logic [63:0] x);
        fred = (x >= FIELD_P) ? (x - FIELD_P) : x;
    endfunction

    function automatic logic [63:0] fadd(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        logic [63:0] t;
        s = {1'b0, a} + {1'b0, b};
        t = s[64] ? (s[63:0] + FIELD_EPS) : s[63:0];
        fadd = fred(t);
    endfunction

    function automatic logic [63:0] fsub(input logic [63:0] a, input logic [63:0] b);
        fsub = (a < b) ? (a - b + FIELD_P) : (a - b);
    endfunction

endpackage

@@ src/goldilocks_field_alu.sv @@
// Top level: iterative Goldilocks prime field ALU with one shared 32x32 multiplier.
//
// Usage: a transaction on the input channel (i_valid/o_ready) carries i_cmd,
// i_operand_a and i_operand_b. One transaction on the output channel
// (o_valid/i_ready) returns o_field_result and o_zero_inverse for it.
// The block takes one item at a time: o_ready is high only while idle.
// Add, sub, neg, inc and dec are computed in the decode state and then
// delivered. A multiply runs four 32x32 partial products through the one
// shared multiplier, then a fold and a final reduce.
// Exponent and inverse use square-and-multiply, LSB first: each exponent bit
// below the highest set bit costs one squaring and each set bit one multiply;
// every multiply is dispatched from the exponent step, then runs the partial
// products, fold and reduce. Exponents stop early once the rest is zero.
// Inverse (exponent p-2: 63 set bits, 63 squarings) uses the same loop;
// divide adds one more multiply by a; an all-ones exponent is the worst case.
// Reset (synchronous, active low) drops any item in flight and clears
// o_valid. While the receiver stalls, the result is held in the output
// register and no new item is taken until it is delivered.
module goldilocks_field_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_cmd,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_field_result,
    output logic        o_zero_inverse
);

    gfa_pkg::t_state r_state, n_state;
    gfa_pkg::t_mop   r_mop;

    logic [3:0]   r_cmd;
    logic [63:0]  r_a, r_b, r_braw;
    logic [63:0]  r_base, r_acc, r_exp;
    logic [63:0]  r_ma, r_mb;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [63:0]  r_fold;
    logic [63:0]  r_res;
    logic         r_flag;
    logic         r_out_valid;

    // Shared multiplier operand selection.
    logic [31:0] w_mx, w_my;
    logic [63:0] w_prod;

    always_comb begin
        w_mx = r_ma[31:0];
        w_my = r_mb[31:0];
        unique case (r_state)
            gfa_pkg::ST_PP1: begin w_mx = r_ma[31:0];  w_my = r_mb[63:32]; end
            gfa_pkg::ST_PP2: begin w_mx = r_ma[63:32]; w_my = r_mb[31:0];  end
            gfa_pkg::ST_PP3: begin w_mx = r_ma[63:32]; w_my = r_mb[63:32]; end
            default: begin w_mx = r_ma[31:0]; w_my = r_mb[31:0]; end
        endcase
    end

    assign w_prod = {32'd0, w_mx} * {32'd0, w_my};

    // Fold the 128-bit product: 2^64 = eps, 2^96 = -1.
    logic [65:0]  w_mid;
    logic [63:0]  w_lo, w_hi, w_t, w_u, w_r;
    logic [64:0]  w_hisum;
    logic [64:0]  w_rs;

    always_comb begin
        w_mid   = {34'd0, r_p00[63:32]} + {34'd0, r_p01[31:0]} + {34'd0, r_p10[31:0]};
        w_lo    = {w_mid[31:0], r_p00[31:0]};
        w_hisum = {1'b0, r_p11} + {33'd0, r_p01[63:32]} + {33'd0, r_p10[63:32]}
                + {31'd0, w_mid[65:32]};
        w_hi    = w_hisum[63:0];
        w_t     = w_lo - {32'd0, w_hi[63:32]};
        if (w_lo < {32'd0, w_hi[63:32]}) begin
            w_t = w_t - gfa_pkg::FIELD_EPS;
        end
        w_u  = {w_hi[31:0], 32'd0} - {32'd0, w_hi[31:0]};
        w_rs = {1'b0, w_t} + {1'b0, w_u};
        w_r  = w_rs[64] ? (w_rs[63:0] + gfa_pkg::FIELD_EPS) : w_rs[63:0];
    end

    logic w_exp_last;
    assign w_exp_last = (r_exp[63:1] == 63'd0);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gfa_pkg::ST_IDLE:   if (i_valid && !r_out_valid) n_state = gfa_pkg::ST_DECODE;
            gfa_pkg::ST_DECODE: begin
                case (r_cmd)
                    gfa_pkg::CMD_MUL: n_state = gfa_pkg::ST_PP0;
                    gfa_pkg::CMD_DIV: n_state = (r_b == 64'd0) ? gfa_pkg::ST_DONE
                                                               : gfa_pkg::ST_EXP_STEP;
                    gfa_pkg::CMD_INV: n_state = (r_a == 64'd0) ? gfa_pkg::ST_DONE
                                                               : gfa_pkg::ST_EXP_STEP;
                    gfa_pkg::CMD_EXP: n_state = gfa_pkg::ST_EXP_STEP;
                    default:          n_state = gfa_pkg::ST_DONE;
                endcase
            end
            gfa_pkg::ST_EXP_STEP: begin
                if (r_exp == 64'd0) begin
                    n_state = (r_cmd == gfa_pkg::CMD_DIV) ? gfa_pkg::ST_PP0 : gfa_pkg::ST_DONE;
                end else if (r_exp[0] || !w_exp_last) begin
                    n_state = gfa_pkg::ST_PP0;
                end else begin
                    n_state = gfa_pkg::ST_EXP_STEP;
                end
            end
            gfa_pkg::ST_PP0: n_state = gfa_pkg::ST_PP1;
            gfa_pkg::ST_PP1: n_state = gfa_pkg::ST_PP2;
            gfa_pkg::ST_PP2: n_state = gfa_pkg::ST_PP3;
            gfa_pkg::ST_PP3: n_state = gfa_pkg::ST_FOLD;
            gfa_pkg::ST_FOLD: n_state = gfa_pkg::ST_FIN;
            gfa_pkg::ST_FIN: begin
                case (r_mop) inside
                    gfa_pkg::MOP_PLAIN, gfa_pkg::MOP_DIVFIN: n_state = gfa_pkg::ST_DONE;
                    default: n_state = gfa_pkg::ST_EXP_STEP;
                endcase
            end
            gfa_pkg::ST_DONE: if (!r_out_valid || i_ready) n_state = gfa_pkg::ST_IDLE;
            default: n_state = gfa_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready        = (r_state == gfa_pkg::ST_IDLE) && !r_out_valid;
        o_valid        = r_out_valid;
        o_field_result = r_res;
        o_zero_inverse = r_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gfa_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_mop       <= gfa_pkg::MOP_PLAIN;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                gfa_pkg::ST_IDLE: begin
                    if (i_valid && !r_out_valid) begin
                        r_cmd  <= i_cmd;
                        r_a    <= gfa_pkg::fred(i_operand_a);
                        r_b    <= gfa_pkg::fred(i_operand_b);
                        r_braw <= i_operand_b;
                    end
                end
                gfa_pkg::ST_DECODE: begin
                    r_acc  <= 64'd1;
                    r_ma   <= r_a;
                    r_mb   <= r_b;
                    r_mop  <= gfa_pkg::MOP_PLAIN;
                    case (r_cmd)
                        gfa_pkg::CMD_ADD: begin
                            r_res  <= gfa_pkg::fadd(r_a, r_b);
                            r_flag <= 1'b0;
                        end
                        gfa_pkg::CMD_SUB: begin
                            r_res  <= gfa_pkg::fsub(r_a, r_b);
                            r_flag <= 1'b0;
                        end
                        gfa_pkg::CMD_NEG: begin
                            r_res  <= gfa_pkg::fsub(64'd0, r_a);
                            r_flag <= 1'b0;
                        end
                        gfa_pkg::CMD_INC: begin
                            r_res  <= gfa_pkg::fadd(r_a, 64'd1);
                            r_flag <= 1'b0;
                        end
                        gfa_pkg::CMD_DEC: begin
                            r_res  <= gfa_pkg::fsub(r_a, 64'd1);
                            r_flag <= 1'b0;
                        end
                        gfa_pkg::CMD_DIV: begin
                            r_res  <= 64'd0;
                            r_base <= r_b;
                            r_exp  <= gfa_pkg::INV_EXP;
                            r_flag <= (r_b == 64'd0);
                        end
                        gfa_pkg::CMD_INV: begin
                            r_res  <= 64'd0;
                            r_base <= r_a;
                            r_exp  <= gfa_pkg::INV_EXP;
                            r_flag <= (r_a == 64'd0);
                        end
                        gfa_pkg::CMD_EXP: begin
                            r_res  <= 64'd0;
                            r_base <= r_a;
                            r_exp  <= r_braw;
                            r_flag <= 1'b0;
                        end
                        default: begin
                            r_res  <= 64'd0;
                            r_flag <= 1'b0;
                        end
                    endcase
                end
                gfa_pkg::ST_EXP_STEP: begin
                    if (r_exp == 64'd0) begin
                        // Finish: divide multiplies a by the inverse; others deliver.
                        r_ma  <= r_a;
                        r_mb  <= r_acc;
                        r_mop <= gfa_pkg::MOP_DIVFIN;
                        r_res <= r_acc;
                    end else if (r_exp[0]) begin
                        r_ma  <= r_acc;
                        r_mb  <= r_base;
                        r_mop <= gfa_pkg::MOP_ACC;
                    end else if (!w_exp_last) begin
                        r_ma  <= r_base;
                        r_mb  <= r_base;
                        r_mop <= gfa_pkg::MOP_SQR;
                    end else begin
                        r_exp <= r_exp >> 1;
                    end
                end
                gfa_pkg::ST_PP0: r_p00 <= w_prod;
                gfa_pkg::ST_PP1: r_p01 <= w_prod;
                gfa_pkg::ST_PP2: r_p10 <= w_prod;
                gfa_pkg::ST_PP3: r_p11 <= w_prod;
                gfa_pkg::ST_FOLD: r_fold <= w_r;
                gfa_pkg::ST_FIN: begin
                    case (r_mop)
                        gfa_pkg::MOP_ACC: begin
                            // Clear the bit; squaring follows if more bits remain.
                            r_acc <= gfa_pkg::fred(r_fold);
                            r_exp <= {r_exp[63:1], 1'b0};
                        end
                        gfa_pkg::MOP_SQR: begin
                            r_base <= gfa_pkg::fred(r_fold);
                            r_exp  <= r_exp >> 1;
                        end
                        default: r_res <= gfa_pkg::fred(r_fold);
                    endcase
                end
                gfa_pkg::ST_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ src/gfa_checker.sv @@
// Checker: port-level assertions for the Goldilocks field ALU, with bind.
module gfa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_field_result,
    input logic        o_zero_inverse
);

    localparam logic [63:0] P = 64'hFFFF_FFFF_0000_0001;

    a_canonical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_field_result < P))
        else $error("result not canonical");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_inverse) |-> (o_field_result == 64'd0))
        else $error("zero inverse flag with nonzero result");

    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while result pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_field_result)))
        else $error("stalled result changed");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready right after acceptance");

endmodule

bind goldilocks_field_alu gfa_checker u_gfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_field_result (o_field_result),
    .o_zero_inverse (o_zero_inverse)
);
